// File: hw/rtl/avl_pkg.sv
// ----------------------------------------------------------------------------
// avl_pkg: shared types and constants
// Beat formats, queue entry format, pitch and choir weight tables.
// ----------------------------------------------------------------------------
package avl_pkg;

  localparam int FREQ_W  = 20;
  localparam int AMP_W   = 16;
  localparam int PITCH_W = 25;
  localparam int ACC_W   = PITCH_W + 3;
  localparam int NUM_W   = AMP_W + 8;
  localparam int QUO_W   = 8;
  localparam int PART_W  = 3;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  localparam logic [5:0] LOW_BASE_LIMIT = 6'd11;

  localparam logic CMD_NOTE  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic       command;
    logic [5:0] voice_base;
    logic [6:0] midi_note;
    logic [6:0] velocity;
  } item_t;

  typedef struct packed {
    logic [5:0]  voice_index;
    logic [15:0] frequency_quarter_hz;
    logic [7:0]  amplitude;
    logic        last;
  } result_t;

  typedef struct packed {
    logic               flush;
    logic               low_base;
    logic [5:0]         base;
    logic [PITCH_W-1:0] pitch;
    logic [6:0]         velocity;
  } cmd_t;

  // top octave pitch, quarter hertz with 8 fraction bits
  function automatic logic [PITCH_W-1:0] avl_top_octave(input logic [3:0] semi);
    logic [PITCH_W-1:0] p;
    unique case (semi)
      4'd0:    p = 25'd17145893;
      4'd1:    p = 25'd18165441;
      4'd2:    p = 25'd19245614;
      4'd3:    p = 25'd20390018;
      4'd4:    p = 25'd21602472;
      4'd5:    p = 25'd22887021;
      4'd6:    p = 25'd24247954;
      4'd7:    p = 25'd25689813;
      4'd8:    p = 25'd27217409;
      4'd9:    p = 25'd28835840;
      4'd10:   p = 25'd30550508;
      4'd11:   p = 25'd32367136;
      default: p = '0;
    endcase
    return p;
  endfunction

  // choir weights times 50; low bases use the weights divided by 2.5
  function automatic logic [7:0] avl_weight(input logic [PART_W-1:0] k, input logic low);
    logic [7:0] w;
    unique case (k)
      3'd0:    w = low ? 8'd70 : 8'd175;
      3'd1:    w = low ? 8'd32 : 8'd80;
      3'd2:    w = low ? 8'd14 : 8'd35;
      3'd3:    w = low ? 8'd74 : 8'd185;
      3'd4:    w = low ? 8'd20 : 8'd50;
      3'd5:    w = low ? 8'd40 : 8'd100;
      default: w = 8'd0;
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/avl_queue.sv
// ----------------------------------------------------------------------------
// avl_queue: small synchronous queue
// Register-based first-in first-out store with full and empty flags.
// ----------------------------------------------------------------------------
module avl_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/avl_front.sv
// ----------------------------------------------------------------------------
// avl_front: item classifier
// Sorts note and flush beats and resolves note pitch and weight set.
// ----------------------------------------------------------------------------
module avl_front (
  input  avl_pkg::item_t item,
  output avl_pkg::cmd_t  cmd
);

  import avl_pkg::*;

  // m / 12 as (m * 171) >> 11, exact for m below 140
  localparam logic [15:0] RECIP_12   = 16'd171;
  localparam int          RECIP_SH   = 11;
  localparam logic [3:0]  TOP_OCTAVE = 4'd11;

  logic [7:0]  note_m;
  logic [15:0] recip_prod;
  logic [3:0]  octave;
  logic [7:0]  semi_full;
  logic [3:0]  semi;

  always_comb begin
    note_m     = {1'b0, item.midi_note} + 8'd12;
    recip_prod = 16'(note_m) * RECIP_12;
    octave     = recip_prod[RECIP_SH+3:RECIP_SH];
    semi_full  = note_m - ({4'b0, octave} * 8'd12);
    semi       = semi_full[3:0];

    cmd.flush    = (item.command == CMD_FLUSH);
    cmd.low_base = (item.voice_base < LOW_BASE_LIMIT);
    cmd.base     = item.voice_base;
    cmd.pitch    = avl_top_octave(semi) >> (TOP_OCTAVE - octave);
    cmd.velocity = item.velocity;
  end

endmodule

// File: hw/rtl/avl_divider.sv
// ----------------------------------------------------------------------------
// avl_divider: iterative restoring divider
// Eight-bit quotient, one bit per cycle; numerator below denom times 256.
// ----------------------------------------------------------------------------
module avl_divider #(
  parameter int DEN_W = 22
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [avl_pkg::NUM_W-1:0] numer,
  input  logic [DEN_W-1:0]          denom,
  output logic                      done,
  output logic [avl_pkg::QUO_W-1:0] quotient
);

  import avl_pkg::*;

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [QUO_W-1:0] low_bits;
  logic [3:0]       steps;
  logic             running;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, low_bits[QUO_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= DEN_W'(numer[NUM_W-1:QUO_W]);
      low_bits <= numer[QUO_W-1:0];
      den      <= denom;
    end else if (running) begin
      rem      <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quotient <= {quotient[QUO_W-2:0], fits};
      low_bits <= {low_bits[QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      steps   <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= 4'(QUO_W);
      end else if (running) begin
        steps <= steps - 1'b1;
        if (steps == 4'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/avl_back.sv
// ----------------------------------------------------------------------------
// avl_back: voice store and sequencer
// Writes note partials, sums amplitudes and emits normalised voice beats.
// ----------------------------------------------------------------------------
module avl_back #(
  parameter int VOICE_COUNT   = 48,
  parameter int PARTIAL_COUNT = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_empty,
  input  avl_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  input  logic             res_full,
  output avl_pkg::result_t res,
  output logic             res_push
);

  import avl_pkg::*;

  localparam int VW    = $clog2(VOICE_COUNT);
  localparam int SUM_W = AMP_W + VW;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_NOTE     = 3'd1;
  localparam logic [2:0] S_SUM      = 3'd2;
  localparam logic [2:0] S_SUM_LAST = 3'd3;
  localparam logic [2:0] S_RD       = 3'd4;
  localparam logic [2:0] S_LOAD     = 3'd5;
  localparam logic [2:0] S_DIV      = 3'd6;
  localparam logic [2:0] S_PUSH     = 3'd7;

  logic [FREQ_W-1:0] freq_mem [VOICE_COUNT];
  logic [AMP_W-1:0]  amp_mem  [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] valid;

  logic [2:0]        state;
  cmd_t              cur;
  logic [PART_W-1:0] k;
  logic [ACC_W-1:0]  f_acc;
  logic [VW-1:0]     idx;
  logic [SUM_W-1:0]  sum;
  logic              acc_en;
  logic [15:0]       out_freq;

  logic [FREQ_W-1:0] rd_freq;
  logic [AMP_W-1:0]  rd_amp;
  logic              rd_ok;
  logic [FREQ_W-1:0] rd_freq_eff;
  logic [AMP_W-1:0]  rd_amp_eff;

  logic [6:0]        vnum;
  logic              wr_en;
  logic [AMP_W-1:0]  amp_w;
  logic              is_last;

  logic              div_start;
  logic              div_done;
  logic [QUO_W-1:0]  div_q;
  logic [NUM_W-1:0]  div_num;

  assign vnum        = {1'b0, cur.base} + 7'(k);
  assign wr_en       = (state == S_NOTE) && (vnum < 7'(VOICE_COUNT));
  assign amp_w       = AMP_W'(cur.velocity) * AMP_W'(avl_weight(k, cur.low_base));
  assign rd_freq_eff = rd_ok ? rd_freq : '0;
  assign rd_amp_eff  = rd_ok ? rd_amp : '0;
  assign is_last     = (idx == VW'(VOICE_COUNT - 1));
  assign cmd_pop     = (state == S_IDLE) && !cmd_empty;
  assign div_start   = (state == S_LOAD);
  assign div_num     = NUM_W'({rd_amp_eff, 8'b0}) - NUM_W'(rd_amp_eff);
  assign res_push    = (state == S_PUSH) && !res_full;

  always_comb begin
    res.voice_index          = 6'(idx);
    res.frequency_quarter_hz = out_freq;
    res.amplitude            = (sum == '0) ? 8'd0 : div_q;
    res.last                 = is_last;
  end

  avl_divider #(
    .DEN_W (SUM_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (div_num),
    .denom    (sum),
    .done     (div_done),
    .quotient (div_q)
  );

  // voice store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      freq_mem[vnum[VW-1:0]] <= f_acc[ACC_W-1:8];
      amp_mem[vnum[VW-1:0]]  <= amp_w;
    end
    rd_freq <= freq_mem[idx];
    rd_amp  <= amp_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[vnum[VW-1:0]] <= 1'b1;
      end
      rd_ok <= valid[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur   <= cmd;
      f_acc <= ACC_W'(cmd.pitch);
    end else if (state == S_NOTE) begin
      f_acc <= f_acc + ACC_W'(cur.pitch);
    end
    if (state == S_LOAD) begin
      out_freq <= (|rd_freq_eff[FREQ_W-1:16]) ? 16'hFFFF : rd_freq_eff[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      k      <= '0;
      idx    <= '0;
      sum    <= '0;
      acc_en <= 1'b0;
    end else begin
      acc_en <= (state == S_SUM);
      if (acc_en) begin
        sum <= sum + SUM_W'(rd_amp_eff);
      end
      unique case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            k   <= '0;
            idx <= '0;
            if (cmd.flush) begin
              sum   <= '0;
              state <= S_SUM;
            end else begin
              state <= S_NOTE;
            end
          end
        end
        S_NOTE: begin
          k <= k + 1'b1;
          if (k == PART_W'(PARTIAL_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_SUM: begin
          if (is_last) begin
            state <= S_SUM_LAST;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SUM_LAST: begin
          idx   <= '0;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!res_full) begin
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/additive_voice_loader.sv
// Note beat: waits in the input queue until the idle back end pops it, then the back end
//   writes its partials; further beats are taken while the input queue has room.
// Flush beat: one amplitude summing pass over all voices, then per voice the steps read,
//   load, quotient divide and push; the push waits while the result queue is full.
// Reset (rst, synchronous): queues empty, all voices read as zero.
// ----------------------------------------------------------------------------
// additive_voice_loader: additive synthesis voice loader
// Keeps per-voice frequency and amplitude, emits normalised voice settings.
// ----------------------------------------------------------------------------
module additive_voice_loader #(
  parameter int VOICE_COUNT   = 48,
  parameter int PARTIAL_COUNT = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  avl_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output avl_pkg::result_t result
);

  import avl_pkg::*;

  cmd_t    front_cmd;
  cmd_t    queued_cmd;
  logic    cmd_empty;
  logic    cmd_pop;
  result_t back_res;
  logic    res_full;
  logic    res_push;

  avl_front u_front (
    .item (item),
    .cmd  (front_cmd)
  );

  avl_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_cmd),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (queued_cmd),
    .empty   (cmd_empty)
  );

  avl_back #(
    .VOICE_COUNT   (VOICE_COUNT),
    .PARTIAL_COUNT (PARTIAL_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (queued_cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res       (back_res),
    .res_push  (res_push)
  );

  avl_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (back_res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

// File: hw/rtl/avl_checker.sv
// ----------------------------------------------------------------------------
// avl_checker: port-level checks
// Watches the result side of the voice loader over time.
// ----------------------------------------------------------------------------
module avl_checker #(
  parameter int VOICE_COUNT = 48
) (
  input logic             clk,
  input logic             rst,
  input logic             push,
  input logic             full,
  input avl_pkg::item_t   item,
  input logic             empty,
  input logic             pop,
  input avl_pkg::result_t result
);

  import avl_pkg::*;

  logic item_flush;
  assign item_flush = push && !full && (item.command == CMD_FLUSH);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ({1'b0, result.voice_index} < 7'(VOICE_COUNT)))
    else $error("voice index out of range");

  a_last_voice: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.last == (result.voice_index == 6'(VOICE_COUNT - 1))))
    else $error("last flag does not match final voice");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop && !item_flush) |=> (!empty && $stable(result)))
    else $error("waiting result beat changed");

endmodule

bind additive_voice_loader avl_checker #(.VOICE_COUNT(VOICE_COUNT)) u_avl_checker (.*);

// File: verif/additive_voice_loader_tb.sv
// ----------------------------------------------------------------------------
// additive_voice_loader_tb: voice loader self-checking bench
// Drives note and flush beats with random idling on both queue sides, keeps a
// bit-exact model of voice frequency and amplitude, and checks every emitted
// voice setting field by field against the predicted settings in order.
// ----------------------------------------------------------------------------
module additive_voice_loader_tb;

  import avl_pkg::*;

  localparam int VOICES   = 48;
  localparam int PARTIALS = 6;

  // pitch of notes 132..143, quarter hertz with 8 fraction bits
  localparam logic [24:0] PITCH_TOP [12] = '{
    25'd17145893, 25'd18165441, 25'd19245614, 25'd20390018,
    25'd21602472, 25'd22887021, 25'd24247954, 25'd25689813,
    25'd27217409, 25'd28835840, 25'd30550508, 25'd32367136
  };
  localparam logic [7:0] CHOIR_HIGH [6] = '{8'd175, 8'd80, 8'd35, 8'd185, 8'd50, 8'd100};
  localparam logic [7:0] CHOIR_LOW  [6] = '{8'd70, 8'd32, 8'd14, 8'd74, 8'd20, 8'd40};

  typedef struct {
    item_t payload;
    bit    drain;
  } send_beat_t;

  logic    clk  = 1'b0;
  logic    rst  = 1'b1;
  logic    push = 1'b0;
  logic    pop  = 1'b0;
  item_t   item = '0;
  logic    full;
  logic    empty;
  result_t result;

  logic [19:0] voice_freq_model [VOICES] = '{default: '0};
  logic [15:0] voice_amp_model  [VOICES] = '{default: '0};

  send_beat_t beats_to_send [$];
  result_t    settings_due [$];

  int mismatch_count = 0;
  bit item_taken     = 1'b0;
  bit result_taken   = 1'b0;
  int send_gap       = 0;
  int hold_gap       = 0;
  int calm_in        = 0;
  int calm_out       = 0;

  additive_voice_loader #(
    .VOICE_COUNT  (VOICES),
    .PARTIAL_COUNT(PARTIALS)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_beat(input logic cmd, input int base, input int note, input int vel,
                            input bit drain);
    send_beat_t b;
    b.payload.command    = cmd;
    b.payload.voice_base = 6'(base);
    b.payload.midi_note  = 7'(note);
    b.payload.velocity   = 7'(vel);
    b.drain              = drain;
    beats_to_send.push_back(b);
  endtask

  // harmonic partials of one note; voices past the end are dropped
  task automatic note_partials_apply(input item_t it);
    int unsigned       m;
    int unsigned       octave;
    int unsigned       semi;
    longint unsigned   f8;
    int                v;
    m      = it.midi_note + 12;
    octave = m / 12;
    semi   = m % 12;
    f8     = PITCH_TOP[semi] >> (11 - octave);
    for (int k = 0; k < PARTIALS; k++) begin
      v = it.voice_base + k;
      if (v < VOICES) begin
        voice_freq_model[v] = 20'(((k + 1) * f8) >> 8);
        voice_amp_model[v]  = 16'(int'(it.velocity) *
                                  int'((it.voice_base < LOW_BASE_LIMIT) ?
                                       CHOIR_LOW[k] : CHOIR_HIGH[k]));
      end
    end
  endtask

  // normalised settings of every voice, amplitudes summing to at most 255
  task automatic flush_settings_predict();
    longint unsigned total;
    result_t         r;
    total = 0;
    for (int v = 0; v < VOICES; v++) total += voice_amp_model[v];
    for (int v = 0; v < VOICES; v++) begin
      r.voice_index          = 6'(v);
      r.frequency_quarter_hz = (voice_freq_model[v] > 20'd65535) ? 16'hFFFF :
                               voice_freq_model[v][15:0];
      r.amplitude            = (total == 0) ? 8'd0 :
                               8'((longint'(voice_amp_model[v]) * 255) / total);
      r.last                 = (v == VOICES - 1);
      settings_due.push_back(r);
    end
  endtask

  // monitor: samples handshakes and outputs at the rising edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      item_taken   = 1'b0;
      result_taken = 1'b0;
    end else begin
      item_taken   = push && !full;
      result_taken = pop && !empty;
      if (result_taken) begin
        if (settings_due.size() == 0) begin
          report_mismatch("unexpected voice setting, voice", result.voice_index, -1);
        end else begin
          want = settings_due.pop_front();
          if (result.voice_index != want.voice_index)
            report_mismatch("voice_index", result.voice_index, want.voice_index);
          if (result.frequency_quarter_hz != want.frequency_quarter_hz)
            report_mismatch("frequency_quarter_hz", result.frequency_quarter_hz,
                            want.frequency_quarter_hz);
          if (result.amplitude != want.amplitude)
            report_mismatch("amplitude", result.amplitude, want.amplitude);
          if (result.last != want.last)
            report_mismatch("last", result.last, want.last);
        end
      end
      if (item_taken) begin
        if (item.command == CMD_NOTE) note_partials_apply(item);
        else flush_settings_predict();
      end
    end
  end

  // driver: next beat at the falling edge, after a random gap; a drain beat also waits until no settings are due
  always @(negedge clk) begin
    logic drive_push;
    if (!rst) begin
      drive_push = push;
      if (item_taken) begin
        drive_push = 1'b0;
        if (calm_in > 0) begin
          calm_in--;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(0, 39) == 0) calm_in = $urandom_range(20, 60);
        end
      end
      if (!drive_push) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (beats_to_send.size() > 0 &&
                     !(beats_to_send[0].drain && settings_due.size() > 0)) begin
          item       <= beats_to_send[0].payload;
          drive_push = 1'b1;
          void'(beats_to_send.pop_front());
        end
      end
      push <= drive_push;
    end
  end

  // receiver: random stalls after each beat taken
  always @(negedge clk) begin
    if (!rst) begin
      if (result_taken) begin
        if (calm_out > 0) begin
          calm_out--;
        end else begin
          hold_gap = pick_gap();
          if ($urandom_range(0, 39) == 0) calm_out = $urandom_range(40, 120);
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    // all voices zero after reset: zero sum and zero frequencies
    queue_beat(CMD_FLUSH, 47, 127, 127, 1'b0);
    queue_beat(CMD_NOTE, 0, 0, 127, 1'b0);
    queue_beat(CMD_NOTE, 10, 127, 127, 1'b0);
    queue_beat(CMD_NOTE, 11, 69, 1, 1'b0);
    queue_beat(CMD_NOTE, 42, 127, 127, 1'b0);
    queue_beat(CMD_NOTE, 47, 60, 64, 1'b0);
    queue_beat(CMD_NOTE, 45, 0, 0, 1'b0);
    queue_beat(CMD_FLUSH, 0, 0, 0, 1'b0);
    queue_beat(CMD_NOTE, 21, 85, 100, 1'b1);
    queue_beat(CMD_NOTE, 31, 42, 85, 1'b0);
    queue_beat(CMD_FLUSH, 31, 85, 42, 1'b0);
    // silence every voice, then zero sum again
    for (int b = 0; b < VOICES; b += PARTIALS)
      queue_beat(CMD_NOTE, b, b * 2 + 30, 0, 1'b0);
    queue_beat(CMD_FLUSH, 16, 21, 10, 1'b1);
    for (int i = 0; i < 260; i++) begin
      if ($urandom_range(0, 6) == 0)
        queue_beat(CMD_FLUSH, $urandom_range(0, 47), $urandom_range(0, 127),
                   $urandom_range(0, 127), $urandom_range(0, 19) == 0);
      else
        queue_beat(CMD_NOTE, $urandom_range(0, 47), $urandom_range(0, 127),
                   ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, 127),
                   $urandom_range(0, 29) == 0);
    end
    queue_beat(CMD_FLUSH, $urandom_range(0, 47), $urandom_range(0, 127),
               $urandom_range(0, 127), 1'b0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (beats_to_send.size() > 0 || push) @(posedge clk);
    while (settings_due.size() > 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (mismatch_count == 0 && settings_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
